// ===== design/qrs_pkg.sv =====
package qrs_pkg;

   // Result classification codes
   typedef enum logic [1:0] {
      KIND_DISTINCT = 2'd0,
      KIND_EQUAL    = 2'd1,
      KIND_COMPLEX  = 2'd2,
      KIND_INVALID  = 2'd3
   } root_kind_type;

   // Root part format
   localparam int RES_WIDTH = 32;
   localparam logic [RES_WIDTH-1:0] RES_MAX = 32'h7FFF_FFFF;
   localparam logic [RES_WIDTH-1:0] RES_MIN = 32'h8000_0000;

   // Queue between front and back
   localparam int QUEUE_DEPTH = 4;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage

// ===== design/qrs_front.sv =====
module qrs_front
   import qrs_pkg::*;
#(
   parameter int COEF_WIDTH = 32
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   output logic                    in_ready,
   input  logic [COEF_WIDTH-1:0]   coef_a,
   input  logic [COEF_WIDTH-1:0]   coef_b,
   input  logic [COEF_WIDTH-1:0]   coef_c,
   input  queue_status_type        queue_status,
   output logic                    push_valid,
   // {kind, sqrt, b, a}
   output logic [3*COEF_WIDTH+2:0] push_data
);

   localparam int W   = COEF_WIDTH;
   localparam int H   = (W + 1) / 2;
   localparam int PX  = 4 * H;
   localparam int PW  = 2 * W;
   localparam int SW  = W + 1;
   localparam int NSQ = 2 * SW;
   localparam int RW  = SW + 2;
   localparam int PLW = 2 * W + 3;

   logic        en;
   logic [SW:0] sq_vld_ff, sq_vld_in;

   // Global stall: the whole pipeline halts when the last stage holds a result and the queue is full
   assign en         = !(sq_vld_ff[SW] && queue_status.full);
   assign in_ready   = en;
   assign push_valid = sq_vld_ff[SW];

   // Stage 1: magnitudes and signs
   logic         v1_ff, v1_in;
   logic [W-1:0] ma_ff, ma_in, mb_ff, mb_in, mc_ff, mc_in;
   logic [W-1:0] a1_ff, a1_in, b1_ff, b1_in;
   logic         sac1_ff, sac1_in, az1_ff, az1_in;

   always_comb begin
      v1_in   = in_valid;
      ma_in   = coef_a[W-1] ? (~coef_a + 1'b1) : coef_a;
      mb_in   = coef_b[W-1] ? (~coef_b + 1'b1) : coef_b;
      mc_in   = coef_c[W-1] ? (~coef_c + 1'b1) : coef_c;
      a1_in   = coef_a;
      b1_in   = coef_b;
      sac1_in = coef_a[W-1] ^ coef_c[W-1];
      az1_in  = (coef_a == '0);
   end

   // Stage 2: partial products on half-width slices
   logic           v2_ff;
   logic [2*H-1:0] bb_ll_ff, bb_ll_in, bb_lh_ff, bb_lh_in, bb_hh_ff, bb_hh_in;
   logic [2*H-1:0] ac_ll_ff, ac_ll_in, ac_lh_ff, ac_lh_in;
   logic [2*H-1:0] ac_hl_ff, ac_hl_in, ac_hh_ff, ac_hh_in;
   logic [W-1:0]   a2_ff, b2_ff;
   logic           sac2_ff, az2_ff;
   logic [H-1:0]   al, ah, bl, bh, cl, ch;

   always_comb begin
      al = ma_ff[H-1:0];
      ah = H'(ma_ff[W-1:H]);
      bl = mb_ff[H-1:0];
      bh = H'(mb_ff[W-1:H]);
      cl = mc_ff[H-1:0];
      ch = H'(mc_ff[W-1:H]);
      bb_ll_in = bl * bl;
      bb_lh_in = bl * bh;
      bb_hh_in = bh * bh;
      ac_ll_in = al * cl;
      ac_lh_in = al * ch;
      ac_hl_in = ah * cl;
      ac_hh_in = ah * ch;
   end

   // Stage 3: full products |b|^2 and |a*c|
   logic          v3_ff;
   logic [PW-1:0] bb_ff, bb_in, ac_ff, ac_in;
   logic [W-1:0]  a3_ff, b3_ff;
   logic          sac3_ff, az3_ff;

   always_comb begin
      bb_in = PW'((PX'(bb_hh_ff) << (2 * H)) + (PX'(bb_lh_ff) << (H + 1))
                  + PX'(bb_ll_ff));
      ac_in = PW'((PX'(ac_hh_ff) << (2 * H))
                  + ((PX'(ac_lh_ff) + PX'(ac_hl_ff)) << H) + PX'(ac_ll_ff));
   end

   // Discriminant magnitude, sign and zero test
   logic [PW+1:0] ac4, bbx, d_sum, d_ab;
   logic [PW+2:0] d_ba;
   logic          d_neg, d_zero;
   logic [NSQ-1:0] d_mag;

   always_comb begin
      ac4    = {ac_ff, 2'b00};
      bbx    = (PW+2)'(bb_ff);
      d_sum  = bbx + ac4;
      d_ab   = ac4 - bbx;
      d_ba   = (PW+3)'(bbx) - (PW+3)'(ac4);
      d_neg  = !sac3_ff && d_ba[PW+2];
      d_zero = (bbx == ac4) && (!sac3_ff || (ac_ff == '0));
      if (sac3_ff) begin
         d_mag = NSQ'(d_sum);
      end else if (d_ba[PW+2]) begin
         d_mag = NSQ'(d_ab);
      end else begin
         d_mag = NSQ'(d_ba[PW+1:0]);
      end
   end

   // Square root pipeline, one root bit per stage
   logic [NSQ-1:0] sq_n_ff    [0:SW];
   logic [NSQ-1:0] sq_n_in    [0:SW];
   logic [RW-1:0]  sq_rem_ff  [0:SW];
   logic [RW-1:0]  sq_rem_in  [0:SW];
   logic [SW-1:0]  sq_root_ff [0:SW];
   logic [SW-1:0]  sq_root_in [0:SW];
   logic [PLW-1:0] sq_pl_ff   [0:SW];
   logic [PLW-1:0] sq_pl_in   [0:SW];

   assign sq_vld_in[0]  = v3_ff;
   assign sq_n_in[0]    = d_mag;
   assign sq_rem_in[0]  = '0;
   assign sq_root_in[0] = '0;
   assign sq_pl_in[0]   = {a3_ff, b3_ff, az3_ff, d_neg, d_zero};

   for (genvar k = 1; k <= SW; k++) begin : g_sq
      logic [1:0]    pair;
      logic [RW-1:0] rsh, trial;
      logic          ge;

      assign pair          = sq_n_ff[k-1][2*(SW-k) +: 2];
      assign rsh           = {sq_rem_ff[k-1][RW-3:0], pair};
      assign trial         = {sq_root_ff[k-1], 2'b01};
      assign ge            = (rsh >= trial);
      assign sq_rem_in[k]  = ge ? (rsh - trial) : rsh;
      assign sq_root_in[k] = {sq_root_ff[k-1][SW-2:0], ge};
      assign sq_n_in[k]    = sq_n_ff[k-1];
      assign sq_pl_in[k]   = sq_pl_ff[k-1];
      assign sq_vld_in[k]  = sq_vld_ff[k-1];
   end

   // Valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff     <= 1'b0;
         v2_ff     <= 1'b0;
         v3_ff     <= 1'b0;
         sq_vld_ff <= '0;
      end else if (en) begin
         v1_ff     <= v1_in;
         v2_ff     <= v1_ff;
         v3_ff     <= v2_ff;
         sq_vld_ff <= sq_vld_in;
      end
   end

   // Payload
   always_ff @(posedge clock) begin
      if (en) begin
         ma_ff      <= ma_in;
         mb_ff      <= mb_in;
         mc_ff      <= mc_in;
         a1_ff      <= a1_in;
         b1_ff      <= b1_in;
         sac1_ff    <= sac1_in;
         az1_ff     <= az1_in;
         bb_ll_ff   <= bb_ll_in;
         bb_lh_ff   <= bb_lh_in;
         bb_hh_ff   <= bb_hh_in;
         ac_ll_ff   <= ac_ll_in;
         ac_lh_ff   <= ac_lh_in;
         ac_hl_ff   <= ac_hl_in;
         ac_hh_ff   <= ac_hh_in;
         a2_ff      <= a1_ff;
         b2_ff      <= b1_ff;
         sac2_ff    <= sac1_ff;
         az2_ff     <= az1_ff;
         bb_ff      <= bb_in;
         ac_ff      <= ac_in;
         a3_ff      <= a2_ff;
         b3_ff      <= b2_ff;
         sac3_ff    <= sac2_ff;
         az3_ff     <= az2_ff;
         sq_n_ff    <= sq_n_in;
         sq_rem_ff  <= sq_rem_in;
         sq_root_ff <= sq_root_in;
         sq_pl_ff   <= sq_pl_in;
      end
   end

   // Classify and hand over to the queue
   logic [PLW-1:0] pl_last;
   root_kind_type  kind;

   always_comb begin
      pl_last = sq_pl_ff[SW];
      if (pl_last[2]) begin
         kind = KIND_INVALID;
      end else if (pl_last[1]) begin
         kind = KIND_COMPLEX;
      end else if (pl_last[0]) begin
         kind = KIND_EQUAL;
      end else begin
         kind = KIND_DISTINCT;
      end
      push_data = {kind, sq_root_ff[SW], pl_last[PLW-1-W -: W], pl_last[PLW-1 -: W]};
   end

endmodule

// ===== design/qrs_queue.sv =====
module qrs_queue
   import qrs_pkg::*;
#(
   parameter int WIDTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   input  logic [WIDTH-1:0] push_data,
   input  logic             pop_ready,
   output logic [WIDTH-1:0] pop_data,
   output queue_status_type status
);

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   logic [WIDTH-1:0] entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             push, pop;

   // Push is refused when full, even with a pop in the same cycle
   always_comb begin
      status.full  = (count_ff == CNT_W'(QUEUE_DEPTH));
      status.empty = (count_ff == '0);
      push         = push_valid && !status.full;
      pop          = pop_ready && !status.empty;
      wr_ptr_in    = push ? PTR_W'(wr_ptr_ff + 1'b1) : wr_ptr_ff;
      rd_ptr_in    = pop ? PTR_W'(rd_ptr_ff + 1'b1) : rd_ptr_ff;
      count_in     = count_ff + CNT_W'(push) - CNT_W'(pop);
      pop_data     = entry_ff[rd_ptr_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== design/qrs_back.sv =====
module qrs_back
   import qrs_pkg::*;
#(
   parameter int COEF_WIDTH = 32,
   parameter int FRAC_BITS  = 16
) (
   input  logic                    clock,
   input  logic                    reset,
   input  queue_status_type        queue_status,
   output logic                    pop_ready,
   // {kind, sqrt, b, a}
   input  logic [3*COEF_WIDTH+2:0] pop_data,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic [RES_WIDTH-1:0]    first_real,
   output logic [RES_WIDTH-1:0]    first_imag,
   output logic [RES_WIDTH-1:0]    second_real,
   output logic [RES_WIDTH-1:0]    second_imag,
   output root_kind_type           root_kind,
   output logic                    overflow
);

   localparam int W  = COEF_WIDTH;
   localparam int F  = FRAC_BITS;
   localparam int SW = W + 1;
   localparam int NX = W + 3;
   localparam int DW = W + 1;
   localparam int NW = W + 2 + F;
   localparam int VW = NW + 2;
   localparam int XW = (VW > RES_WIDTH) ? VW : RES_WIDTH + 1;

   logic en;
   logic rsp_valid_ff;

   assign en        = !rsp_valid_ff || rsp_ready;
   assign pop_ready = en;

   // B0: numerator -b or -b-s
   logic                 b0_vld_ff;
   root_kind_type        b0_kind_ff, b0_kind_in;
   logic [W-1:0]         b0_a_ff, b0_a_in;
   logic [SW-1:0]        b0_s_ff, b0_s_in;
   logic signed [NX-1:0] b0_num_ff, b0_num_in;
   logic signed [NX-1:0] bx, sx;

   always_comb begin
      b0_a_in    = pop_data[W-1:0];
      b0_s_in    = pop_data[3*W:2*W];
      b0_kind_in = root_kind_type'(pop_data[3*W+2:3*W+1]);
      bx         = NX'($signed(pop_data[2*W-1:W]));
      sx         = $signed(NX'(b0_s_in));
      b0_num_in  = (b0_kind_in == KIND_COMPLEX) ? -bx : (-bx - sx);
   end

   // B1: magnitudes, divisors and quotient signs
   logic          a_neg, num_neg;
   logic [W-1:0]  ma;
   logic [NX-1:0] mn;

   logic [NW:0]   dv_vld_ff, dv_vld_in;
   logic [NW-1:0] dv_n1_ff [0:NW];
   logic [NW-1:0] dv_n1_in [0:NW];
   logic [NW-1:0] dv_n2_ff [0:NW];
   logic [NW-1:0] dv_n2_in [0:NW];
   logic [DW-1:0] dv_d1_ff [0:NW];
   logic [DW-1:0] dv_d1_in [0:NW];
   logic [DW-1:0] dv_d2_ff [0:NW];
   logic [DW-1:0] dv_d2_in [0:NW];
   logic [DW-1:0] dv_r1_ff [0:NW];
   logic [DW-1:0] dv_r1_in [0:NW];
   logic [DW-1:0] dv_r2_ff [0:NW];
   logic [DW-1:0] dv_r2_in [0:NW];
   logic [NW-1:0] dv_q1_ff [0:NW];
   logic [NW-1:0] dv_q1_in [0:NW];
   logic [NW-1:0] dv_q2_ff [0:NW];
   logic [NW-1:0] dv_q2_in [0:NW];
   // {kind, sign1, sign2}
   logic [3:0]    dv_pl_ff [0:NW];
   logic [3:0]    dv_pl_in [0:NW];

   always_comb begin
      a_neg   = b0_a_ff[W-1];
      num_neg = b0_num_ff[NX-1];
      ma      = a_neg ? (~b0_a_ff + 1'b1) : b0_a_ff;
      mn      = num_neg ? NX'(-b0_num_ff) : NX'(b0_num_ff);
      dv_vld_in[0] = b0_vld_ff;
      dv_n1_in[0]  = {mn[W+1:0], {F{1'b0}}};
      dv_n2_in[0]  = NW'({b0_s_ff, {F{1'b0}}});
      dv_d1_in[0]  = {ma, 1'b0};
      dv_d2_in[0]  = (b0_kind_ff == KIND_DISTINCT) ? {1'b0, ma} : {ma, 1'b0};
      dv_r1_in[0]  = '0;
      dv_r2_in[0]  = '0;
      dv_q1_in[0]  = '0;
      dv_q2_in[0]  = '0;
      dv_pl_in[0]  = {b0_kind_ff, num_neg ^ a_neg, a_neg};
   end

   // Two restoring dividers, one quotient bit per stage
   for (genvar k = 1; k <= NW; k++) begin : g_div
      logic [DW:0] rsh1, rsh2, sub1, sub2;
      logic        ge1, ge2;

      assign rsh1 = {dv_r1_ff[k-1], dv_n1_ff[k-1][NW-k]};
      assign rsh2 = {dv_r2_ff[k-1], dv_n2_ff[k-1][NW-k]};
      assign sub1 = rsh1 - {1'b0, dv_d1_ff[k-1]};
      assign sub2 = rsh2 - {1'b0, dv_d2_ff[k-1]};
      assign ge1  = (rsh1 >= {1'b0, dv_d1_ff[k-1]});
      assign ge2  = (rsh2 >= {1'b0, dv_d2_ff[k-1]});

      assign dv_r1_in[k]  = ge1 ? sub1[DW-1:0] : rsh1[DW-1:0];
      assign dv_r2_in[k]  = ge2 ? sub2[DW-1:0] : rsh2[DW-1:0];
      assign dv_q1_in[k]  = {dv_q1_ff[k-1][NW-2:0], ge1};
      assign dv_q2_in[k]  = {dv_q2_ff[k-1][NW-2:0], ge2};
      assign dv_n1_in[k]  = dv_n1_ff[k-1];
      assign dv_n2_in[k]  = dv_n2_ff[k-1];
      assign dv_d1_in[k]  = dv_d1_ff[k-1];
      assign dv_d2_in[k]  = dv_d2_ff[k-1];
      assign dv_pl_in[k]  = dv_pl_ff[k-1];
      assign dv_vld_in[k] = dv_vld_ff[k-1];
   end

   // E1: signed quotients, truncated toward zero
   logic               e1_vld_ff;
   root_kind_type      e1_kind_ff, e1_kind_in;
   logic signed [NW:0] q1s_ff, q1s_in, q2s_ff, q2s_in;
   logic [3:0]         pl_last;

   always_comb begin
      pl_last    = dv_pl_ff[NW];
      e1_kind_in = root_kind_type'(pl_last[3:2]);
      q1s_in     = pl_last[1] ? -$signed({1'b0, dv_q1_ff[NW]}) : $signed({1'b0, dv_q1_ff[NW]});
      q2s_in     = pl_last[0] ? -$signed({1'b0, dv_q2_ff[NW]}) : $signed({1'b0, dv_q2_ff[NW]});
   end

   // E2: assemble root parts
   logic                 e2_vld_ff;
   root_kind_type        e2_kind_ff;
   logic signed [VW-1:0] r1re_ff, r1re_in, r1im_ff, r1im_in;
   logic signed [VW-1:0] r2re_ff, r2re_in, r2im_ff, r2im_in;
   logic signed [VW-1:0] q1x, q2x;

   always_comb begin
      q1x     = VW'(q1s_ff);
      q2x     = VW'(q2s_ff);
      r1re_in = '0;
      r1im_in = '0;
      r2re_in = '0;
      r2im_in = '0;
      unique case (e1_kind_ff)
         KIND_DISTINCT: begin
            r1re_in = q1x + q2x;
            r2re_in = q1x;
         end
         KIND_EQUAL: begin
            r1re_in = q1x;
            r2re_in = q1x;
         end
         KIND_COMPLEX: begin
            r1re_in = q1x;
            r2re_in = q1x;
            r1im_in = q2x;
            r2im_in = -q2x;
         end
         default: begin
         end
      endcase
   end

   // Saturation to the result range; msb is the overflow flag
   function automatic logic [RES_WIDTH:0] sat_fn(input logic signed [VW-1:0] v);
      logic signed [XW-1:0] vx;
      logic                 hi, lo;
      vx = XW'(v);
      hi = (vx > $signed({{(XW-RES_WIDTH){1'b0}}, RES_MAX}));
      lo = (vx < $signed({{(XW-RES_WIDTH){1'b1}}, RES_MIN}));
      if (hi) begin
         return {1'b1, RES_MAX};
      end else if (lo) begin
         return {1'b1, RES_MIN};
      end
      return {1'b0, vx[RES_WIDTH-1:0]};
   endfunction

   // Output register
   logic [RES_WIDTH-1:0] fr_ff, fi_ff, sr_ff, si_ff;
   logic [RES_WIDTH:0]   fr_in, fi_in, sr_in, si_in;
   root_kind_type        kind_ff;
   logic                 ovf_ff, ovf_in;

   always_comb begin
      fr_in  = sat_fn(r1re_ff);
      fi_in  = sat_fn(r1im_ff);
      sr_in  = sat_fn(r2re_ff);
      si_in  = sat_fn(r2im_ff);
      ovf_in = fr_in[RES_WIDTH] | fi_in[RES_WIDTH] | sr_in[RES_WIDTH] | si_in[RES_WIDTH];
   end

   // Valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         b0_vld_ff    <= 1'b0;
         dv_vld_ff    <= '0;
         e1_vld_ff    <= 1'b0;
         e2_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         b0_vld_ff    <= !queue_status.empty;
         dv_vld_ff    <= dv_vld_in;
         e1_vld_ff    <= dv_vld_ff[NW];
         e2_vld_ff    <= e1_vld_ff;
         rsp_valid_ff <= e2_vld_ff;
      end
   end

   // Payload
   always_ff @(posedge clock) begin
      if (en) begin
         b0_kind_ff <= b0_kind_in;
         b0_a_ff    <= b0_a_in;
         b0_s_ff    <= b0_s_in;
         b0_num_ff  <= b0_num_in;
         dv_n1_ff   <= dv_n1_in;
         dv_n2_ff   <= dv_n2_in;
         dv_d1_ff   <= dv_d1_in;
         dv_d2_ff   <= dv_d2_in;
         dv_r1_ff   <= dv_r1_in;
         dv_r2_ff   <= dv_r2_in;
         dv_q1_ff   <= dv_q1_in;
         dv_q2_ff   <= dv_q2_in;
         dv_pl_ff   <= dv_pl_in;
         e1_kind_ff <= e1_kind_in;
         q1s_ff     <= q1s_in;
         q2s_ff     <= q2s_in;
         e2_kind_ff <= e1_kind_ff;
         r1re_ff    <= r1re_in;
         r1im_ff    <= r1im_in;
         r2re_ff    <= r2re_in;
         r2im_ff    <= r2im_in;
         fr_ff      <= fr_in[RES_WIDTH-1:0];
         fi_ff      <= fi_in[RES_WIDTH-1:0];
         sr_ff      <= sr_in[RES_WIDTH-1:0];
         si_ff      <= si_in[RES_WIDTH-1:0];
         kind_ff    <= e2_kind_ff;
         ovf_ff     <= ovf_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign first_real  = fr_ff;
   assign first_imag  = fi_ff;
   assign second_real = sr_ff;
   assign second_imag = si_ff;
   assign root_kind   = kind_ff;
   assign overflow    = ovf_ff;

endmodule

// ===== design/quadratic_root_solver.sv =====
// Roots of a*x^2 + b*x + c, signed fixed point in and out.
// Path: the registers from the input transaction to rsp_tvalid include COEF_WIDTH+1
//   square root stages, the queue and COEF_WIDTH+2+FRAC_BITS divider stages.
// Throughput: one transaction per cycle while not stalled; the front stalls when its
//   last stage holds a result and the queue is full, the back when rsp_tready is low.
// Reset: synchronous, clears valid bits and the queue; no result is pending after it.
module quadratic_root_solver
   import qrs_pkg::*;
#(
   parameter int COEF_WIDTH = 32,
   parameter int FRAC_BITS  = 16,
   localparam int REQ_DATA_WIDTH = ((3 * COEF_WIDTH + 7) / 8) * 8
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   // coef_a, coef_b, coef_c, zero pad
   input  logic [REQ_DATA_WIDTH-1:0] req_tdata,
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   // first_real, first_imag, second_real, second_imag
   output logic [4*RES_WIDTH-1:0]    rsp_tdata,
   // root_kind[1:0], overflow[2]
   output logic [2:0]                rsp_tuser
);

   localparam int W = COEF_WIDTH;

   queue_status_type     queue_status;
   logic                 push_valid, pop_ready;
   logic [3*W+2:0]       push_data, pop_data;
   logic [RES_WIDTH-1:0] first_real, first_imag, second_real, second_imag;
   root_kind_type        root_kind;
   logic                 overflow;

   // Front: discriminant and square root
   qrs_front #(
      .COEF_WIDTH (COEF_WIDTH)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (req_tvalid),
      .in_ready     (req_tready),
      .coef_a       (req_tdata[W-1:0]),
      .coef_b       (req_tdata[2*W-1:W]),
      .coef_c       (req_tdata[3*W-1:2*W]),
      .queue_status (queue_status),
      .push_valid   (push_valid),
      .push_data    (push_data)
   );

   qrs_queue #(
      .WIDTH (3*W+3)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_data  (push_data),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data),
      .status     (queue_status)
   );

   // Back: divisions, root assembly, saturation
   qrs_back #(
      .COEF_WIDTH (COEF_WIDTH),
      .FRAC_BITS  (FRAC_BITS)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .queue_status (queue_status),
      .pop_ready    (pop_ready),
      .pop_data     (pop_data),
      .rsp_valid    (rsp_tvalid),
      .rsp_ready    (rsp_tready),
      .first_real   (first_real),
      .first_imag   (first_imag),
      .second_real  (second_real),
      .second_imag  (second_imag),
      .root_kind    (root_kind),
      .overflow     (overflow)
   );

   assign rsp_tdata = {second_imag, second_real, first_imag, first_real};
   assign rsp_tuser = {overflow, root_kind};

endmodule
